[design/sms_pkg.sv]
// sms_pkg: shared types and constants of the spi master shift engine
// used by the channel interfaces and every module of the block
// no dependencies
package sms_pkg;

    // word length of one exchange
    localparam int DEFAULT_DATA_BITS = 8;

    // fixed payload widths
    localparam int BYTE_W    = 8;
    localparam int HALF_W    = 16;
    localparam int TICK_W    = HALF_W + 1;  // gap counts up to two half periods
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = HALF_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD    = 8'd3;

    // sequencer stage codes
    localparam logic [1:0] STAGE_IDLE  = 2'd0;
    localparam logic [1:0] STAGE_SHIFT = 2'd1;
    localparam logic [1:0] STAGE_GAP   = 2'd2;

    // configuration seen by the sequencer
    typedef struct packed {
        logic              clock_polarity;
        logic              clock_phase;
        logic              lsb_first;
        logic [HALF_W-1:0] half_period;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic              sck;
        logic              mosi;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
    } t_result;

endpackage

[design/sms_in_if.sv]
// sms_in_if: input channel of the spi master shift engine, one item per tick
// depends on sms_pkg
interface sms_in_if
    import sms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [BYTE_W-1:0] tx_byte;
    logic              miso;

    modport source (output valid, output start_req, output tx_byte, output miso,
                    input ready);
    modport sink   (input valid, input start_req, input tx_byte, input miso,
                    output ready);
endinterface

[design/sms_out_if.sv]
// sms_out_if: result channel of the spi master shift engine
// depends on sms_pkg
interface sms_out_if
    import sms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              sck;
    logic              mosi;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output sck, output mosi, output busy_res,
                    output done_res, output rx_byte, input ready);
    modport sink   (input valid, input sck, input mosi, input busy_res,
                    input done_res, input rx_byte, output ready);
endinterface

[design/sms_cfg.sv]
// sms_cfg: configuration registers of the spi master shift engine
// depends on sms_pkg
module sms_cfg
    import sms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_polarity <= 1'b0;
            r_cfg.clock_phase    <= 1'b0;
            r_cfg.lsb_first      <= 1'b0;
            r_cfg.half_period    <= HALF_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLOCK_POLARITY: r_cfg.clock_polarity <= i_cfg_data[0];
                CFG_CLOCK_PHASE:    r_cfg.clock_phase    <= i_cfg_data[0];
                CFG_LSB_FIRST:      r_cfg.lsb_first      <= i_cfg_data[0];
                CFG_HALF_PERIOD:    r_cfg.half_period    <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/sms_core.sv]
// sms_core: shift sequencer of the spi master, advances one tick per accepted item
// and forms the result item from the updated state
// depends on sms_pkg
module sms_core
    import sms_pkg::*;
#(
    parameter int DATA_BITS = DEFAULT_DATA_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_start_req,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_miso,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam int BL_W = $clog2(DATA_BITS + 1);

    logic [DATA_BITS-1:0] r_tx_shift, n_tx_shift;
    logic [DATA_BITS-1:0] r_rx_shift, n_rx_shift;
    logic [BL_W-1:0]      r_bits_left, n_bits_left;
    logic [TICK_W-1:0]    r_tick_count, n_tick_count;
    logic                 r_half_phase, n_half_phase;
    logic [1:0]           r_stage, n_stage;
    logic                 r_sck_level, n_sck_level;
    logic                 r_mosi_level, n_mosi_level;
    logic                 w_done;

    logic [TICK_W-1:0]          w_half_ticks;
    logic [TICK_W-1:0]          w_gap_ticks;
    logic [TICK_W-1:0]          w_tick_inc;
    logic [DATA_BITS+BYTE_W-1:0] w_tx_ext;
    logic [DATA_BITS-1:0]       w_tx_src;
    logic [DATA_BITS-1:0]       w_tx_shifted;
    logic                       w_tx_bit;
    logic [DATA_BITS-1:0]       w_rx_sampled;
    logic [DATA_BITS+BYTE_W-1:0] w_rx_ext;

    // a zero half period counts as one tick
    assign w_half_ticks = (i_cfg.half_period == '0) ? TICK_W'(1)
                                                    : {1'b0, i_cfg.half_period};
    assign w_gap_ticks  = {w_half_ticks[TICK_W-2:0], 1'b0};
    assign w_tick_inc   = r_tick_count + TICK_W'(1);

    // transmit shifter: loaded word on a start, else the running shift word
    assign w_tx_ext     = {{DATA_BITS{1'b0}}, i_tx_byte};
    assign w_tx_src     = (r_stage == STAGE_SHIFT) ? r_tx_shift : w_tx_ext[DATA_BITS-1:0];
    assign w_tx_bit     = i_cfg.lsb_first ? w_tx_src[0] : w_tx_src[DATA_BITS-1];
    assign w_tx_shifted = i_cfg.lsb_first ? (w_tx_src >> 1) : (w_tx_src << 1);

    // receive shifter
    assign w_rx_sampled = i_cfg.lsb_first ? {i_miso, r_rx_shift[DATA_BITS-1:1]}
                                          : {r_rx_shift[DATA_BITS-2:0], i_miso};

    // next state for one tick
    always_comb begin
        n_tx_shift   = r_tx_shift;
        n_rx_shift   = r_rx_shift;
        n_bits_left  = r_bits_left;
        n_tick_count = r_tick_count;
        n_half_phase = r_half_phase;
        n_stage      = r_stage;
        n_sck_level  = r_sck_level;
        n_mosi_level = r_mosi_level;
        w_done       = 1'b0;
        unique case (r_stage)
            STAGE_SHIFT: begin
                n_tick_count = w_tick_inc;
                if (w_tick_inc >= w_half_ticks) begin
                    n_tick_count = '0;
                    if (!r_half_phase) begin
                        // leading edge
                        n_sck_level  = ~i_cfg.clock_phase;
                        n_rx_shift   = w_rx_sampled;
                        n_half_phase = 1'b1;
                    end else begin
                        // trailing edge, end of one bit
                        n_half_phase = 1'b0;
                        if (!i_cfg.clock_phase) n_sck_level = 1'b0;
                        n_bits_left = (r_bits_left != '0) ? r_bits_left - BL_W'(1) : '0;
                        if (n_bits_left == '0) begin
                            n_sck_level = 1'b0;
                            n_stage     = STAGE_GAP;
                        end else begin
                            if (i_cfg.clock_phase) n_sck_level = 1'b1;
                            n_mosi_level = w_tx_bit;
                            n_tx_shift   = w_tx_shifted;
                        end
                    end
                end
            end
            STAGE_GAP: begin
                n_tick_count = w_tick_inc;
                if (w_tick_inc >= w_gap_ticks) begin
                    n_tick_count = '0;
                    n_stage      = STAGE_IDLE;
                    w_done       = 1'b1;
                end
            end
            default: begin
                n_stage = STAGE_IDLE;
                if (i_start_req) begin
                    n_rx_shift   = '0;
                    n_bits_left  = BL_W'(DATA_BITS);
                    n_tick_count = '0;
                    n_half_phase = 1'b0;
                    n_stage      = STAGE_SHIFT;
                    n_sck_level  = i_cfg.clock_phase;
                    n_mosi_level = w_tx_bit;
                    n_tx_shift   = w_tx_shifted;
                end
            end
        endcase
    end

    // state registers advance only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_shift   <= '0;
            r_rx_shift   <= '0;
            r_bits_left  <= '0;
            r_tick_count <= '0;
            r_half_phase <= 1'b0;
            r_stage      <= STAGE_IDLE;
            r_sck_level  <= 1'b0;
            r_mosi_level <= 1'b0;
        end else if (i_step) begin
            r_tx_shift   <= n_tx_shift;
            r_rx_shift   <= n_rx_shift;
            r_bits_left  <= n_bits_left;
            r_tick_count <= n_tick_count;
            r_half_phase <= n_half_phase;
            r_stage      <= n_stage;
            r_sck_level  <= n_sck_level;
            r_mosi_level <= n_mosi_level;
        end
    end

    // result item from the updated state
    assign w_rx_ext = {{BYTE_W{1'b0}}, n_rx_shift};

    always_comb begin
        o_result.sck      = i_cfg.clock_polarity ^ n_sck_level;
        o_result.mosi     = n_mosi_level;
        o_result.busy_res = (n_stage != STAGE_IDLE);
        o_result.done_res = w_done;
        o_result.rx_byte  = w_done ? w_rx_ext[BYTE_W-1:0] : '0;
    end

endmodule

[design/sms_out_reg.sv]
// sms_out_reg: result register between the sequencer and the result channel
// depends on sms_pkg and sms_out_if
module sms_out_reg
    import sms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_result          i_result,
    output logic             o_free,
    sms_out_if.source        o_out
);

    logic    r_valid;
    t_result r_result;

    // room for a new item when empty or when the held one leaves now
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.sck      = r_result.sck;
    assign o_out.mosi     = r_result.mosi;
    assign o_out.busy_res = r_result.busy_res;
    assign o_out.done_res = r_result.done_res;
    assign o_out.rx_byte  = r_result.rx_byte;

endmodule

[design/spi_master_shift_engine_top.sv]
// spi_master_shift_engine_top: full-duplex spi master, modes 0 to 3
// depends on sms_pkg, sms_in_if, sms_out_if, sms_cfg, sms_core, sms_out_reg
//
// usage
//   i_in_ch carries one item per system tick: start_req, tx_byte and the
//   sampled miso level. every accepted item advances the shift sequencer by
//   one tick and yields exactly one result item on o_out_ch: sck and mosi pin
//   levels, busy_res, done_res and rx_byte (nonzero only with done_res).
//   configuration (polarity, phase, bit order, half period) is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while the channel is quiet.
// throughput
//   one item per cycle unless o_out_ch stalls; the result of an item is visible
//   in the cycle after it is accepted, held in a single result register. the
//   sequencer update is a 17-bit increment and compare plus the shifter muxes.
// reset
//   synchronous, active low: sequencer idle, shifters and pins low,
//   configuration back to mode 0, msb first, half period of one tick.
// stalls
//   when o_out_ch is not ready and the result register is full, i_in_ch.ready
//   drops and the sequencer holds; no tick is lost or repeated.
module spi_master_shift_engine_top
    import sms_pkg::*;
#(
    parameter int DATA_BITS = DEFAULT_DATA_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    sms_in_if.sink               i_in_ch,
    sms_out_if.source            o_out_ch
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_free;
    logic    w_step;

    // configuration registers
    sms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input handshake
    assign i_in_ch.ready = w_free;
    assign w_step        = i_in_ch.valid && w_free;

    // shift sequencer
    sms_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_start_req (i_in_ch.start_req),
        .i_tx_byte   (i_in_ch.tx_byte),
        .i_miso      (i_in_ch.miso),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    // result register
    sms_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_result (w_result),
        .o_free   (w_free),
        .o_out    (o_out_ch)
    );

    // done ends the gap, so busy is already low on that item
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.done_res) |-> !o_out_ch.busy_res)
        else $error("done_res with busy_res high");

    // received byte is only shown with done
    a_rx_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.done_res) |-> (o_out_ch.rx_byte == '0))
        else $error("rx_byte nonzero without done_res");

    // an empty result register never stalls the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_ch.valid |-> i_in_ch.ready)
        else $error("input stalled with empty result register");

    // an accepted item always produces a result item next cycle
    a_item_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> o_out_ch.valid)
        else $error("accepted item produced no result");

endmodule

[tb/tb.sv]
// tb: self-checking bench for spi_master_shift_engine_top, one item per sequencer tick
// depends on sms_pkg, sms_in_if, sms_out_if and the top level of the block
`timescale 1ns / 100ps

module tb;
    import sms_pkg::*;

    localparam int WORD_BITS = DEFAULT_DATA_BITS;

    // register indexes past the end of the list, writes there change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_BEYOND_LIST = CFG_HALF_PERIOD + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP   = '1;

    localparam int MAX_PRINTED = 40;

    // tracks the shift sequencer tick by tick and checks the pin levels it yields
    class spi_tick_checker;
        // configuration copy
        bit                cpol;
        bit                cpha;
        bit                lsb_first;
        logic [HALF_W-1:0] half_period;

        // sequencer copy
        logic [WORD_BITS-1:0] tx_word;
        logic [WORD_BITS-1:0] rx_word;
        int unsigned          bits_left;
        int unsigned          tick_count;
        bit                   half_phase;
        logic [1:0]           seq_stage;
        bit                   sck_active;
        bit                   mosi_level;

        t_result     pins_due[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned ticks;
        int unsigned exchanges_done;
        bit [3:0]    modes_done;

        function new();
            cpol        = 1'b0;
            cpha        = 1'b0;
            lsb_first   = 1'b0;
            half_period = HALF_W'(1);
            tx_word     = '0;
            rx_word     = '0;
            bits_left   = 0;
            tick_count  = 0;
            half_phase  = 1'b0;
            seq_stage   = STAGE_IDLE;
            sck_active  = 1'b0;
            mosi_level  = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_CLOCK_POLARITY: cpol = data[0];
                CFG_CLOCK_PHASE:    cpha = data[0];
                CFG_LSB_FIRST:      lsb_first = data[0];
                CFG_HALF_PERIOD:    half_period = data[HALF_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned half_ticks();
            return (half_period == 0) ? 1 : half_period;
        endfunction

        function bit is_busy();
            return seq_stage != STAGE_IDLE;
        endfunction

        function int unsigned pending();
            return pins_due.size();
        endfunction

        // put the next bit on mosi
        function void shift_out();
            if (lsb_first) begin
                mosi_level = tx_word[0];
                tx_word    = tx_word >> 1;
            end else begin
                mosi_level = tx_word[WORD_BITS-1];
                tx_word    = {tx_word[WORD_BITS-2:0], 1'b0};
            end
        endfunction

        // take one miso bit into the receive word
        function void shift_in(bit level);
            if (lsb_first)
                rx_word = {level, rx_word[WORD_BITS-1:1]};
            else
                rx_word = {rx_word[WORD_BITS-2:0], level};
        endfunction

        // advance one tick on an accepted item and queue the pin levels it yields
        function void note_tick(bit start, logic [BYTE_W-1:0] txb, bit miso);
            t_result want;
            bit      done;
            done = 1'b0;
            case (seq_stage)
                STAGE_SHIFT: begin
                    tick_count++;
                    if (tick_count >= half_ticks()) begin
                        tick_count = 0;
                        if (!half_phase) begin
                            // leading half ends: edge and sample
                            sck_active = !cpha;
                            shift_in(miso);
                            half_phase = 1'b1;
                        end else begin
                            half_phase = 1'b0;
                            if (!cpha) sck_active = 1'b0;
                            if (bits_left != 0) bits_left--;
                            if (bits_left == 0) begin
                                sck_active = 1'b0;
                                seq_stage  = STAGE_GAP;
                            end else begin
                                if (cpha) sck_active = 1'b1;
                                shift_out();
                            end
                        end
                    end
                end
                STAGE_GAP: begin
                    tick_count++;
                    if (tick_count >= 2 * half_ticks()) begin
                        tick_count = 0;
                        seq_stage  = STAGE_IDLE;
                        done       = 1'b1;
                    end
                end
                default: begin
                    seq_stage = STAGE_IDLE;
                    if (start) begin
                        tx_word    = WORD_BITS'(txb);
                        rx_word    = '0;
                        bits_left  = WORD_BITS;
                        tick_count = 0;
                        half_phase = 1'b0;
                        seq_stage  = STAGE_SHIFT;
                        sck_active = cpha;
                        shift_out();
                    end
                end
            endcase

            want.sck      = cpol ^ sck_active;
            want.mosi     = mosi_level;
            want.busy_res = (seq_stage != STAGE_IDLE);
            want.done_res = done;
            want.rx_byte  = done ? BYTE_W'(rx_word) : '0;
            pins_due.push_back(want);
            ticks++;
            if (done) begin
                exchanges_done++;
                modes_done[{cpol, cpha}] = 1'b1;
            end
        endfunction

        task report_error(string msg);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] ERROR %s", $realtime, msg);
            mismatches++;
        endtask

        // compare one result item with the oldest expectation, field by field
        task check_pins(t_result got);
            t_result want;
            if (pins_due.size() == 0) begin
                report_error("result item with no expectation pending");
                return;
            end
            want = pins_due.pop_front();
            checked++;
            if (got.sck !== want.sck)
                report_error($sformatf("item %0d sck got %b want %b",
                                       checked, got.sck, want.sck));
            if (got.mosi !== want.mosi)
                report_error($sformatf("item %0d mosi got %b want %b",
                                       checked, got.mosi, want.mosi));
            if (got.busy_res !== want.busy_res)
                report_error($sformatf("item %0d busy_res got %b want %b",
                                       checked, got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                report_error($sformatf("item %0d done_res got %b want %b",
                                       checked, got.done_res, want.done_res));
            if (got.rx_byte !== want.rx_byte)
                report_error($sformatf("item %0d rx_byte got %h want %h",
                                       checked, got.rx_byte, want.rx_byte));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    sms_in_if  in_ch ();
    sms_out_if out_ch ();

    spi_master_shift_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    spi_tick_checker board = new();

    bit          idling_on;
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned stall_left;
    int unsigned cfg_writes;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side ready, stalls in random bursts
    initial begin
        out_ch.ready = 1'b1;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (idling_on && stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(9, 1) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.sck      = out_ch.sck;
            got.mosi     = out_ch.mosi;
            got.busy_res = out_ch.busy_res;
            got.done_res = out_ch.done_res;
            got.rx_byte  = out_ch.rx_byte;
            board.check_pins(got);
        end
    end

    // send one tick item, maybe after a random gap, and wait for it to be taken
    task automatic send_tick(bit start, logic [BYTE_W-1:0] txb, bit miso);
        int unsigned gap;
        if (idling_on && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(9, 1);
            @(negedge i_clk);
            in_ch.valid     <= 1'b0;
            in_ch.start_req <= 1'($urandom_range(1));
            in_ch.tx_byte   <= BYTE_W'($urandom_range(255));
            in_ch.miso      <= 1'($urandom_range(1));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.start_req <= start;
        in_ch.tx_byte   <= txb;
        in_ch.miso      <= miso;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_tick(start, txb, miso);
    endtask

    // stop sending and wait until every queued result has come back
    task automatic settle_channel();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        board.set_reg(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random configuration, mostly short half periods
    task automatic pick_config();
        int unsigned r;
        logic [HALF_W-1:0] hp;
        r = $urandom_range(99);
        if (r < 60)      hp = HALF_W'($urandom_range(3, 1));
        else if (r < 85) hp = HALF_W'($urandom_range(12, 4));
        else if (r < 92) hp = '0;
        else if (r < 97) hp = HALF_W'($urandom_range(400, 100));
        else             hp = '1;
        if ($urandom_range(3) != 0)
            write_cfg(CFG_CLOCK_POLARITY, CFG_DAT_W'($urandom_range(1)));
        if ($urandom_range(3) != 0)
            write_cfg(CFG_CLOCK_PHASE, CFG_DAT_W'($urandom_range(1)));
        if ($urandom_range(3) != 0)
            write_cfg(CFG_LSB_FIRST, CFG_DAT_W'($urandom_range(1)));
        if ($urandom_range(3) != 0) write_cfg(CFG_HALF_PERIOD, hp);
        if ($urandom_range(9) == 0)
            write_cfg(CFG_IDX_W'($urandom_range(CFG_INDEX_TOP, CFG_BEYOND_LIST)),
                      CFG_DAT_W'($urandom_range(16'hFFFF)));
    endtask

    // random items: starts mostly when idle, starts while busy as noise
    task automatic run_phase(int unsigned len);
        bit start;
        for (int unsigned i = 0; i < len; i++) begin
            start = board.is_busy() ? ($urandom_range(3) == 0) : ($urandom_range(3) != 0);
            send_tick(start, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // main sequence
    initial begin
        int unsigned done_mark;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.start_req = 1'b0;
        in_ch.tx_byte   = '0;
        in_ch.miso      = 1'b0;
        idling_on       = 1'b1;
        gap_pct         = 15;
        stall_pct       = 15;
        cfg_writes      = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // writes past the register list are ignored, zero half period acts as one
        write_cfg(CFG_BEYOND_LIST, '1);
        write_cfg(CFG_INDEX_TOP, '1);
        write_cfg(CFG_HALF_PERIOD, '0);

        // all-ones byte in mode 0, starts while busy are dropped
        send_tick(1'b1, 8'hFF, 1'b1);
        repeat (7) send_tick(1'b1, 8'h00, 1'($urandom_range(1)));

        // mode changes mid-exchange, then the longest half period
        settle_channel();
        write_cfg(CFG_CLOCK_POLARITY, 16'd1);
        write_cfg(CFG_CLOCK_PHASE, 16'd1);
        write_cfg(CFG_LSB_FIRST, 16'd1);
        write_cfg(CFG_HALF_PERIOD, '1);
        repeat (2) send_tick(1'b0, 8'hA5, 1'b1);

        // shrink the half period below the count already reached
        settle_channel();
        write_cfg(CFG_HALF_PERIOD, 16'd1);
        done_mark = board.exchanges_done;
        while (board.exchanges_done == done_mark) send_tick(1'b1, 8'h00, 1'b0);
        // all-zero byte started right after done
        send_tick(1'b1, 8'h00, 1'b1);

        // random phases with mixed idling
        while (board.ticks < 750) begin
            settle_channel();
            pick_config();
            gap_pct   = $urandom_range(2) * 15;
            stall_pct = $urandom_range(2) * 15;
            run_phase($urandom_range(120, 20));
        end

        // closing stretch with no idling on either side
        settle_channel();
        pick_config();
        idling_on = 1'b0;
        run_phase(80);
        settle_channel();

        $display("checked %0d tick items, %0d completed exchanges, %0d register writes",
                 board.checked, board.exchanges_done, cfg_writes);
        $display("spi modes finished with done: %b (bit index = {cpol, cpha})",
                 board.modes_done);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
